// ===== rtl/lrld_pkg.sv =====
// ----------------------------------------------------------------------------
// lrld_pkg
// Shared types and codes of the layout run-length decoder: request and status
// codes, stream markers, parser and sequencer state encodings, word structs.
// ----------------------------------------------------------------------------
package lrld_pkg;

    // request codes
    localparam logic [1:0] REQ_STREAM  = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    // status codes
    localparam logic [2:0] ST_HEADER   = 3'd0;
    localparam logic [2:0] ST_CONTROL  = 3'd1;
    localparam logic [2:0] ST_RUN      = 3'd2;
    localparam logic [2:0] ST_END      = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;
    localparam logic [2:0] ST_IGNORED  = 3'd5;
    localparam logic [2:0] ST_READ     = 3'd6;
    localparam logic [2:0] ST_RESTART  = 3'd7;

    // stream markers
    localparam logic [7:0] END_MARK   = 8'hFF;
    localparam int         REPEAT_BIT = 7;

    // stream parser phase
    typedef enum logic [5:0] {
        PH_WIDTH   = 6'b000001,
        PH_HEIGHT  = 6'b000010,
        PH_SCENES  = 6'b000100,
        PH_CONTROL = 6'b001000,
        PH_VALUE   = 6'b010000,
        PH_DONE    = 6'b100000
    } t_phase;

    // item sequencer
    typedef enum logic [3:0] {
        SQ_IDLE = 4'b0001,
        SQ_RUN  = 4'b0010,
        SQ_READ = 4'b0100,
        SQ_EMIT = 4'b1000
    } t_seq;

    // input word
    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic [9:0] read_index;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  read_value;
        logic [10:0] write_count;
        logic [7:0]  level_width;
        logic [7:0]  level_height;
        logic [7:0]  scenes_used;
    } t_out_word;

endpackage

// ===== rtl/lrld_store.sv =====
// ----------------------------------------------------------------------------
// lrld_store
// Layout store: single write port, single read port, read data registered
// in the cycle after the read enable.
// ----------------------------------------------------------------------------
module lrld_store #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== rtl/layout_run_length_decoder.sv =====
// Header, control, end, restart and ignored words go via the emit state to the
// output register; reads go via the read state (store read) and then the emit
// state; a run of n entries writes one store entry per cycle in the run state
// before emitting. One word at a time: no new word is taken until the last
// has been emitted. Reset clears parser, counters and header registers; the
// store is not swept: entries at or above the high-water mark read as zero.
// ----------------------------------------------------------------------------
// layout_run_length_decoder
// Decodes a header plus control/value run pairs into a layout store and
// serves indexed reads of that store.
// ----------------------------------------------------------------------------
module layout_run_length_decoder #(
    parameter int LAYOUT_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lrld_pkg::t_in_word i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lrld_pkg::t_out_word o_out_word
);

    localparam int AW = $clog2(LAYOUT_DEPTH);
    localparam int CW = (AW + 1 > 11) ? AW + 1 : 11;
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(LAYOUT_DEPTH);

    // control state
    lrld_pkg::t_seq   r_seq, n_seq;
    lrld_pkg::t_phase r_phase, n_phase;
    logic [AW:0]      r_wr_idx, n_wr_idx;
    logic [AW:0]      r_fill, n_fill;
    logic [7:0]       r_held, n_held;
    logic [7:0]       r_width, n_width;
    logic [7:0]       r_height, n_height;
    logic [7:0]       r_scenes, n_scenes;
    logic             r_out_valid;

    // item payload
    logic [6:0]          r_cnt, n_cnt;
    logic [7:0]          r_val, n_val;
    logic                r_drop, n_drop;
    logic [2:0]          r_status, n_status;
    logic [7:0]          r_rval, n_rval;
    logic                r_hit, n_hit;
    lrld_pkg::t_out_word r_out;

    logic          in_acc;
    logic          out_free;
    logic          wr_full;
    logic          wr_en;
    logic          rd_en;
    logic [7:0]    rd_data;
    logic [CW-1:0] idx_ext;
    logic [CW-1:0] fill_ext;
    logic [CW-1:0] cnt_ext;

    assign o_in_stall = (r_seq != lrld_pkg::SQ_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign wr_full    = (r_wr_idx == DEPTH_W);
    assign idx_ext    = CW'(i_in_word.read_index);
    assign fill_ext   = CW'(r_fill);
    assign cnt_ext    = CW'(r_wr_idx);

    // layout store
    lrld_store #(
        .DEPTH(LAYOUT_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wr_idx[AW-1:0]),
        .i_wr_data (r_val),
        .i_rd_en   (rd_en),
        .i_rd_addr (idx_ext[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // sequencer and parser next state
    always_comb begin
        n_seq    = r_seq;
        n_phase  = r_phase;
        n_wr_idx = r_wr_idx;
        n_fill   = r_fill;
        n_held   = r_held;
        n_width  = r_width;
        n_height = r_height;
        n_scenes = r_scenes;
        n_cnt    = r_cnt;
        n_val    = r_val;
        n_drop   = r_drop;
        n_status = r_status;
        n_rval   = r_rval;
        n_hit    = r_hit;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        case (r_seq)
            lrld_pkg::SQ_IDLE: begin
                if (in_acc) begin
                    n_seq  = lrld_pkg::SQ_EMIT;
                    n_rval = '0;
                    case (i_in_word.req_type)
                        lrld_pkg::REQ_STREAM: begin
                            case (r_phase)
                                lrld_pkg::PH_WIDTH: begin
                                    n_width  = i_in_word.data_byte;
                                    n_phase  = lrld_pkg::PH_HEIGHT;
                                    n_status = lrld_pkg::ST_HEADER;
                                end
                                lrld_pkg::PH_HEIGHT: begin
                                    n_height = i_in_word.data_byte;
                                    n_phase  = lrld_pkg::PH_SCENES;
                                    n_status = lrld_pkg::ST_HEADER;
                                end
                                lrld_pkg::PH_SCENES: begin
                                    n_scenes = i_in_word.data_byte;
                                    n_phase  = lrld_pkg::PH_CONTROL;
                                    n_status = lrld_pkg::ST_HEADER;
                                end
                                lrld_pkg::PH_CONTROL: begin
                                    if (i_in_word.data_byte == lrld_pkg::END_MARK) begin
                                        n_phase  = lrld_pkg::PH_DONE;
                                        n_status = lrld_pkg::ST_END;
                                    end else begin
                                        n_held   = i_in_word.data_byte;
                                        n_phase  = lrld_pkg::PH_VALUE;
                                        n_status = lrld_pkg::ST_CONTROL;
                                    end
                                end
                                lrld_pkg::PH_VALUE: begin
                                    n_phase  = lrld_pkg::PH_CONTROL;
                                    n_status = lrld_pkg::ST_RUN;
                                    n_drop   = 1'b0;
                                    n_val    = i_in_word.data_byte;
                                    n_cnt    = r_held[6:0];
                                    // empty run finishes at once
                                    if (r_held[6:0] != 7'd0) begin
                                        n_seq = lrld_pkg::SQ_RUN;
                                    end
                                end
                                default: begin
                                    n_status = lrld_pkg::ST_IGNORED;
                                end
                            endcase
                        end
                        lrld_pkg::REQ_READ: begin
                            rd_en    = 1'b1;
                            n_hit    = (idx_ext < fill_ext);
                            n_status = lrld_pkg::ST_READ;
                            n_seq    = lrld_pkg::SQ_READ;
                        end
                        lrld_pkg::REQ_RESTART: begin
                            n_phase  = lrld_pkg::PH_WIDTH;
                            n_held   = '0;
                            n_wr_idx = '0;
                            n_width  = '0;
                            n_height = '0;
                            n_scenes = '0;
                            n_status = lrld_pkg::ST_RESTART;
                        end
                        default: begin
                            n_status = lrld_pkg::ST_IGNORED;
                        end
                    endcase
                end
            end
            lrld_pkg::SQ_RUN: begin
                // one store write per cycle, dropped once the store is full
                if (!wr_full) begin
                    wr_en    = 1'b1;
                    n_wr_idx = r_wr_idx + 1'b1;
                    if (r_wr_idx == r_fill) begin
                        n_fill = r_fill + 1'b1;
                    end
                end else begin
                    n_drop = 1'b1;
                end
                if (!r_held[lrld_pkg::REPEAT_BIT]) begin
                    n_val = r_val + 8'd1;
                end
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    n_seq    = lrld_pkg::SQ_EMIT;
                    n_status = (r_drop || wr_full) ? lrld_pkg::ST_OVERFLOW
                                                   : lrld_pkg::ST_RUN;
                end
            end
            lrld_pkg::SQ_READ: begin
                // never-written entries read as zero
                n_rval = r_hit ? rd_data : 8'd0;
                n_seq  = lrld_pkg::SQ_EMIT;
            end
            lrld_pkg::SQ_EMIT: begin
                if (out_free) begin
                    n_seq = lrld_pkg::SQ_IDLE;
                end
            end
            default: begin
                n_seq = lrld_pkg::SQ_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq    <= lrld_pkg::SQ_IDLE;
            r_phase  <= lrld_pkg::PH_WIDTH;
            r_wr_idx <= '0;
            r_fill   <= '0;
            r_held   <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_scenes <= '0;
        end else begin
            r_seq    <= n_seq;
            r_phase  <= n_phase;
            r_wr_idx <= n_wr_idx;
            r_fill   <= n_fill;
            r_held   <= n_held;
            r_width  <= n_width;
            r_height <= n_height;
            r_scenes <= n_scenes;
        end
    end

    // item payload registers
    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_val    <= n_val;
        r_drop   <= n_drop;
        r_status <= n_status;
        r_rval   <= n_rval;
        r_hit    <= n_hit;
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_seq == lrld_pkg::SQ_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_seq == lrld_pkg::SQ_EMIT && out_free) begin
            r_out.status       <= r_status;
            r_out.read_value   <= r_rval;
            r_out.write_count  <= cnt_ext[10:0];
            r_out.level_width  <= r_width;
            r_out.level_height <= r_height;
            r_out.scenes_used  <= r_scenes;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // checks
    a_seq_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_seq))
        else $error("sequencer state not one-hot");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_idx <= DEPTH_W)
        else $error("write index past store depth");

    a_fill_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_idx <= r_fill)
        else $error("high-water mark below write index");

    a_run_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == lrld_pkg::SQ_RUN) |-> (r_cnt != 7'd0))
        else $error("run active with zero count");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == lrld_pkg::SQ_EMIT && out_free) |=> r_out_valid)
        else $error("finished word not loaded into output register");

endmodule
